### hw/rtl/bipsp_pkg.sv
// Shared types, port numbers and command codes of the board glue block.
// No dependencies; every other file of the block imports this package.
package bipsp_pkg;

    localparam int SAMPLE_ADDR_BITS_DEF = 17;
    localparam int SAMPLE_ADDR_W        = 17;
    localparam int KEY_ROWS             = 6;
    localparam int KEY_ROW_W            = 8;

    typedef enum logic [1:0] {
        FUNC_IO_WRITE    = 2'd0,
        FUNC_IO_READ     = 2'd1,
        FUNC_VRAM_WRITE  = 2'd2,
        FUNC_SAMPLE_TICK = 2'd3
    } func_t;

    // I/O port numbers (low byte of the bus address).
    localparam logic [7:0] PORT_KEYS       = 8'h20;
    localparam logic [7:0] PORT_CTRL_A     = 8'h30;
    localparam logic [7:0] PORT_CTRL_B     = 8'h31;
    localparam logic [7:0] PORT_KEY_SELECT = 8'h32;
    localparam logic [7:0] PORT_SMP_START  = 8'h34;
    localparam logic [7:0] PORT_SMP_END    = 8'h35;

    // Commands on control port A.
    localparam logic [7:0] CMD_ROM_HIGH_CLR = 8'h00;
    localparam logic [7:0] CMD_ROM_HIGH_SET = 8'h01;
    localparam logic [7:0] CMD_FLIP_CLR     = 8'h02;
    localparam logic [7:0] CMD_FLIP_SET     = 8'h03;
    localparam logic [7:0] CMD_PAL0_CLR     = 8'h04;
    localparam logic [7:0] CMD_PAL0_SET     = 8'h05;
    localparam logic [7:0] CMD_PAL1_CLR     = 8'h06;
    localparam logic [7:0] CMD_PAL1_SET     = 8'h07;
    localparam logic [7:0] CMD_PAL2_CLR     = 8'h08;
    localparam logic [7:0] CMD_PAL2_SET     = 8'h09;
    localparam logic [7:0] CMD_DISP_OFF     = 8'h0a;
    localparam logic [7:0] CMD_DISP_ON      = 8'h0b;
    localparam logic [7:0] CMD_LAYER0       = 8'h0e;
    localparam logic [7:0] CMD_LAYER1       = 8'h0f;

    // Commands on control port B.
    localparam logic [7:0] CMD_HALF_LO      = 8'h0a;
    localparam logic [7:0] CMD_HALF_HI      = 8'h0b;
    localparam logic [7:0] CMD_ROM_LOW_CLR  = 8'h0c;
    localparam logic [7:0] CMD_ROM_LOW_SET  = 8'h0d;

    typedef struct packed {
        func_t        func;
        logic [14:0]  bus_address;
        logic [7:0]   write_data;
        logic [47:0]  key_rows;
    } item_t;

    // Latch values that the current item reads.
    typedef struct packed {
        logic [2:0] palette_bank;
        logic       layer_select;
        logic [5:0] key_row_select;
    } ctl_t;

    // Status after the item.
    typedef struct packed {
        logic [1:0] rom_bank;
        logic [2:0] control_flags;
    } status_t;

    typedef struct packed {
        logic [SAMPLE_ADDR_W-1:0] sample_addr;
        logic                     sample_valid;
        logic                     busy;
    } smp_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       pixel_valid;
        logic       pixel_layer;
        logic [7:0] pixel_row;
        logic [7:0] pixel_col;
        logic [7:0] color_left;
        logic [7:0] color_right;
    } pix_t;

endpackage

### hw/rtl/bipsp_latches.sv
// Control latches written over the I/O port: palette bank, flip, display,
// layer select, program ROM bank and key-row select. Uses bipsp_pkg.
module bipsp_latches import bipsp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  item_t   item,
    output ctl_t    ctl,
    output status_t status
);

    logic [2:0] palette_bank_reg, palette_bank_next;
    logic       layer_select_reg, layer_select_next;
    logic       flip_reg, flip_next;
    logic       display_on_reg, display_on_next;
    logic       rom_high_reg, rom_high_next;
    logic       rom_low_reg, rom_low_next;
    logic [5:0] key_select_reg, key_select_next;
    logic       io_write;
    logic [7:0] port;

    assign io_write = (item.func == FUNC_IO_WRITE);
    assign port     = item.bus_address[7:0];

    always_comb begin
        palette_bank_next = palette_bank_reg;
        layer_select_next = layer_select_reg;
        flip_next         = flip_reg;
        display_on_next   = display_on_reg;
        rom_high_next     = rom_high_reg;
        rom_low_next      = rom_low_reg;
        key_select_next   = key_select_reg;
        if (io_write && port == PORT_CTRL_A) begin
            unique case (item.write_data)
                CMD_ROM_HIGH_CLR: rom_high_next = 1'b0;
                CMD_ROM_HIGH_SET: rom_high_next = 1'b1;
                CMD_FLIP_CLR:     flip_next = 1'b0;
                CMD_FLIP_SET:     flip_next = 1'b1;
                CMD_PAL0_CLR:     palette_bank_next[0] = 1'b0;
                CMD_PAL0_SET:     palette_bank_next[0] = 1'b1;
                CMD_PAL1_CLR:     palette_bank_next[1] = 1'b0;
                CMD_PAL1_SET:     palette_bank_next[1] = 1'b1;
                CMD_PAL2_CLR:     palette_bank_next[2] = 1'b0;
                CMD_PAL2_SET:     palette_bank_next[2] = 1'b1;
                CMD_DISP_OFF:     display_on_next = 1'b0;
                CMD_DISP_ON:      display_on_next = 1'b1;
                CMD_LAYER0:       layer_select_next = 1'b0;
                CMD_LAYER1:       layer_select_next = 1'b1;
                default: ;
            endcase
        end
        if (io_write && port == PORT_CTRL_B) begin
            unique case (item.write_data)
                CMD_ROM_LOW_CLR: rom_low_next = 1'b0;
                CMD_ROM_LOW_SET: rom_low_next = 1'b1;
                default: ;
            endcase
        end
        if (io_write && port == PORT_KEY_SELECT) begin
            key_select_next = item.write_data[5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            palette_bank_reg <= '0;
            layer_select_reg <= 1'b0;
            flip_reg         <= 1'b0;
            display_on_reg   <= 1'b0;
            rom_high_reg     <= 1'b0;
            rom_low_reg      <= 1'b0;
            key_select_reg   <= '0;
        end else if (step) begin
            palette_bank_reg <= palette_bank_next;
            layer_select_reg <= layer_select_next;
            flip_reg         <= flip_next;
            display_on_reg   <= display_on_next;
            rom_high_reg     <= rom_high_next;
            rom_low_reg      <= rom_low_next;
            key_select_reg   <= key_select_next;
        end
    end

    assign ctl.palette_bank   = palette_bank_reg;
    assign ctl.layer_select   = layer_select_reg;
    assign ctl.key_row_select = key_select_reg;

    // A redraw is requested whenever the palette bank actually changes.
    assign status.rom_bank      = {rom_high_next, rom_low_next};
    assign status.control_flags = {(palette_bank_next != palette_bank_reg),
                                   display_on_next, flip_next};

endmodule

### hw/rtl/bipsp_sampler.sv
// Sample player: start/end page latches, ROM half select and the address
// pointer that steps once per tick while busy. Uses bipsp_pkg.
module bipsp_sampler import bipsp_pkg::*; #(
    parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  step,
    input  item_t item,
    output smp_t  smp
);

    logic [7:0]                  start_page_reg, start_page_next;
    logic [7:0]                  end_page_reg, end_page_next;
    logic                        half_reg, half_next;
    logic                        busy_reg, busy_next;
    logic [SAMPLE_ADDR_BITS-1:0] pointer_reg, pointer_next;
    logic [SAMPLE_ADDR_BITS-1:0] pointer_inc;
    logic [SAMPLE_ADDR_BITS-1:0] rom_addr;
    logic                        io_write;
    logic                        emit;
    logic [7:0]                  port;

    assign io_write    = (item.func == FUNC_IO_WRITE);
    assign port        = item.bus_address[7:0];
    assign emit        = (item.func == FUNC_SAMPLE_TICK) && busy_reg;
    assign pointer_inc = pointer_reg + 1'b1;
    // The half select adds half the address space; any carry drops out.
    assign rom_addr    = pointer_reg + {half_reg, {(SAMPLE_ADDR_BITS-1){1'b0}}};

    always_comb begin
        start_page_next = start_page_reg;
        end_page_next   = end_page_reg;
        half_next       = half_reg;
        busy_next       = busy_reg;
        pointer_next    = pointer_reg;
        if (io_write && port == PORT_CTRL_B) begin
            unique case (item.write_data)
                CMD_HALF_LO: half_next = 1'b0;
                CMD_HALF_HI: half_next = 1'b1;
                default: ;
            endcase
        end
        if (io_write && port == PORT_SMP_START) begin
            start_page_next = item.write_data;
        end
        if (io_write && port == PORT_SMP_END) begin
            end_page_next = item.write_data;
            pointer_next  = SAMPLE_ADDR_BITS'({start_page_reg, 8'h00});
            busy_next     = 1'b1;
        end
        if (emit) begin
            pointer_next = pointer_inc;
            if (pointer_inc[15:8] == end_page_reg) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_page_reg <= '0;
            end_page_reg   <= '0;
            half_reg       <= 1'b0;
            busy_reg       <= 1'b0;
            pointer_reg    <= '0;
        end else if (step) begin
            start_page_reg <= start_page_next;
            end_page_reg   <= end_page_next;
            half_reg       <= half_next;
            busy_reg       <= busy_next;
            pointer_reg    <= pointer_next;
        end
    end

    assign smp.sample_addr  = emit ? SAMPLE_ADDR_W'(rom_addr) : '0;
    assign smp.sample_valid = emit;
    assign smp.busy         = busy_next;

endmodule

### hw/rtl/bipsp_pixel.sv
// Pixel pair colouring for video RAM writes and the key-matrix read.
// Pure combinational datapath; uses bipsp_pkg.
module bipsp_pixel import bipsp_pkg::*; (
    input  item_t item,
    input  ctl_t  ctl,
    output pix_t  pix
);

    logic [7:0] base;
    logic [7:0] lo_ext, hi_ext;
    logic [7:0] lo_color, hi_color;
    logic [7:0] key_or;
    logic       vram;
    logic       key_read;

    assign vram     = (item.func == FUNC_VRAM_WRITE);
    assign key_read = (item.func == FUNC_IO_READ) && (item.bus_address[7:0] == PORT_KEYS);
    assign base     = {ctl.palette_bank, 5'b0_0000};
    assign lo_ext   = {4'b0000, item.write_data[3:0]};
    assign hi_ext   = {4'b0000, item.write_data[7:4]};

    // Layer 1 keeps a zero nibble transparent and uses the upper half of
    // the bank; layer 0 uses the lower half.
    always_comb begin
        if (ctl.layer_select) begin
            lo_color = (lo_ext == 8'h00) ? 8'h00 : lo_ext + base + 8'h10;
            hi_color = (hi_ext == 8'h00) ? 8'h00 : hi_ext + base + 8'h10;
        end else begin
            lo_color = lo_ext + base;
            hi_color = hi_ext + base;
        end
    end

    always_comb begin
        key_or = '0;
        for (int i = 0; i < KEY_ROWS; i++) begin
            if (ctl.key_row_select[i]) begin
                key_or = key_or | item.key_rows[i*KEY_ROW_W +: KEY_ROW_W];
            end
        end
    end

    assign pix.read_data   = key_read ? key_or : 8'h00;
    assign pix.pixel_valid = vram;
    assign pix.pixel_layer = vram & ctl.layer_select;
    assign pix.pixel_row   = vram ? item.bus_address[14:7] : 8'h00;
    assign pix.pixel_col   = vram ? {item.bus_address[6:0], 1'b0} : 8'h00;
    assign pix.color_left  = vram ? lo_color : 8'h00;
    assign pix.color_right = vram ? hi_color : 8'h00;

endmodule

### hw/rtl/board_io_pixel_plot_sample_player_top.sv
// Board glue top level: input register, control latches, sample player,
// pixel/key datapath and result register. Uses bipsp_pkg and all bipsp_* modules.
//
// Usage:
//   The s_ channel carries one request per item: func selects an I/O port
//   write, a key-port read, a video RAM write or a sample tick. Every
//   request yields exactly one result on the m_ channel, in order.
//   An accepted request sits in the input register until it advances; then
//   the latch update and result logic load the result register, which
//   raises m_valid. Throughput is one request per cycle; a request waits
//   in the input register only while the result register is full and
//   m_ready is low.
//   When the receiver stalls, the result holds, one more request is taken
//   into the input register, and then s_ready drops until m_ready returns.
//   Status fields (rom_bank, control_flags, player_busy) show the latch values after
//   the request. All latches and the player are cleared by a synchronous active-low
//   aresetn; the user, not s_ready, keeps requests from being accepted in reset.
module board_io_pixel_plot_sample_player_top import bipsp_pkg::*; #(
    parameter int SAMPLE_ADDR_BITS = SAMPLE_ADDR_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_func,
    input  logic [14:0]              s_bus_address,
    input  logic [7:0]               s_write_data,
    input  logic [47:0]              s_key_rows,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_read_data,
    output logic [SAMPLE_ADDR_W-1:0] m_sample_addr,
    output logic                     m_sample_valid,
    output logic                     m_pixel_valid,
    output logic                     m_pixel_layer,
    output logic [7:0]               m_pixel_row,
    output logic [7:0]               m_pixel_col,
    output logic [7:0]               m_color_left,
    output logic [7:0]               m_color_right,
    output logic [1:0]               m_rom_bank,
    output logic [2:0]               m_control_flags,
    output logic                     m_player_busy
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    pix_t    pix_reg;
    smp_t    smp_reg;
    status_t status_reg;
    logic    advance;
    ctl_t    ctl;
    status_t status;
    smp_t    smp;
    pix_t    pix;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.func        <= func_t'(s_func);
            in_item_reg.bus_address <= s_bus_address;
            in_item_reg.write_data  <= s_write_data;
            in_item_reg.key_rows    <= s_key_rows;
        end
    end

    bipsp_latches u_latches (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .ctl     (ctl),
        .status  (status)
    );

    bipsp_sampler #(
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS)
    ) u_sampler (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .smp     (smp)
    );

    bipsp_pixel u_pixel (
        .item (in_item_reg),
        .ctl  (ctl),
        .pix  (pix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pix_reg    <= pix;
            smp_reg    <= smp;
            status_reg <= status;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_read_data     = pix_reg.read_data;
    assign m_sample_addr   = smp_reg.sample_addr;
    assign m_sample_valid  = smp_reg.sample_valid;
    assign m_pixel_valid   = pix_reg.pixel_valid;
    assign m_pixel_layer   = pix_reg.pixel_layer;
    assign m_pixel_row     = pix_reg.pixel_row;
    assign m_pixel_col     = pix_reg.pixel_col;
    assign m_color_left    = pix_reg.color_left;
    assign m_color_right   = pix_reg.color_right;
    assign m_rom_bank      = status_reg.rom_bank;
    assign m_control_flags = status_reg.control_flags;
    assign m_player_busy   = smp_reg.busy;

    // The input register only backs up while the result register is stuck.
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without a full, stalled pipeline");

    // A request that leaves the input register always lands in the result register.
    a_advance_fills_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced request did not produce a result");

    // A result never carries both a pixel pair and a sample address.
    a_pixel_sample_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(m_pixel_valid && m_sample_valid))
        else $error("pixel and sample valid in one result");

    // A sample address is only emitted by a tick.
    a_sample_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && smp.sample_valid |-> in_item_reg.func == FUNC_SAMPLE_TICK)
        else $error("sample address emitted outside a tick");

endmodule
